// ----- sv/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on i_clk, quiet while reset is low
`define KNOS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define KNOS_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/knos_pkg.sv -----
`timescale 1ns / 1ps

package knos_pkg;

    localparam int MAX_KEEP   = 16;
    localparam int COORD_BITS = 16;
    localparam int DIST_BITS  = 2 * COORD_BITS;
    localparam int KEEP_BITS  = 5;
    localparam int LIMIT_BITS = $clog2(MAX_KEEP + 1);

    // flips the sign bit so signed coordinates order as unsigned
    localparam logic [COORD_BITS-1:0] SIGN_FLIP = {1'b1, {(COORD_BITS - 1){1'b0}}};

    typedef struct packed {
        logic [DIST_BITS-1:0]         sq_dist;
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
    } t_entry;

    typedef struct packed {
        logic   valid;
        logic   stay;
        t_entry entry;
    } t_link;

    typedef enum logic {
        ST_RUN,
        ST_EMIT
    } t_state;

    // eviction order: distance, then signed x, then signed y
    function automatic logic f_greater(t_entry a, t_entry b);
        return {a.sq_dist, a.x ^ SIGN_FLIP, a.y ^ SIGN_FLIP} >
               {b.sq_dist, b.x ^ SIGN_FLIP, b.y ^ SIGN_FLIP};
    endfunction

    function automatic logic [COORD_BITS-1:0] f_abs(logic signed [COORD_BITS-1:0] v);
        return v[COORD_BITS-1] ? COORD_BITS'(-v) : COORD_BITS'(v);
    endfunction

endpackage

// ----- sv/knos_dist.sv -----
`timescale 1ns / 1ps

module knos_dist (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  logic signed [knos_pkg::COORD_BITS-1:0] i_x,
    input  logic signed [knos_pkg::COORD_BITS-1:0] i_y,
    input  logic                                i_end,
    output logic                                o_valid,
    output logic                                o_end,
    output logic                                o_end_pending,
    output knos_pkg::t_entry                    o_entry
);
    import knos_pkg::*;

    logic [COORD_BITS-1:0]        w_ax;
    logic [COORD_BITS-1:0]        w_ay;
    logic                         r_s1_valid;
    logic                         r_s1_end;
    logic signed [COORD_BITS-1:0] r_s1_x;
    logic signed [COORD_BITS-1:0] r_s1_y;
    logic [DIST_BITS-1:0]         r_s1_sqx;
    logic [DIST_BITS-1:0]         r_s1_sqy;
    logic                         r_s2_valid;
    logic                         r_s2_end;
    t_entry                       r_s2_entry;

    assign w_ax = f_abs(i_x);
    assign w_ay = f_abs(i_y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_valid;
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_end            <= i_end;
        r_s1_x              <= i_x;
        r_s1_y              <= i_y;
        r_s1_sqx            <= DIST_BITS'(w_ax) * DIST_BITS'(w_ax);
        r_s1_sqy            <= DIST_BITS'(w_ay) * DIST_BITS'(w_ay);
        r_s2_end            <= r_s1_end;
        r_s2_entry.sq_dist  <= r_s1_sqx + r_s1_sqy;
        r_s2_entry.x        <= r_s1_x;
        r_s2_entry.y        <= r_s1_y;
    end

    assign o_valid       = r_s2_valid;
    assign o_end         = r_s2_end;
    assign o_entry       = r_s2_entry;
    assign o_end_pending = (r_s1_valid && r_s1_end) || (r_s2_valid && r_s2_end);

endmodule

// ----- sv/knos_cell.sv -----
`timescale 1ns / 1ps

module knos_cell (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_insert,
    input  logic             i_shift,
    input  logic             i_keep,
    input  knos_pkg::t_entry i_new,
    input  knos_pkg::t_link  i_up,
    output knos_pkg::t_link  o_link
);
    import knos_pkg::*;

    logic   r_valid;
    t_entry r_entry;
    logic   n_valid;
    t_entry n_entry;
    logic   w_stay;

    // this entry is not greater than the incoming point, so it holds its place
    assign w_stay = r_valid && !f_greater(r_entry, i_new);

    always_comb begin
        n_valid = r_valid;
        n_entry = r_entry;
        if (i_shift) begin
            n_valid = i_up.valid;
            n_entry = i_up.entry;
        end else if (i_insert) begin
            if (!w_stay) begin
                if (i_up.stay) begin
                    n_valid = 1'b1;
                    n_entry = i_new;
                end else begin
                    n_valid = i_up.valid;
                    n_entry = i_up.entry;
                end
            end
            // slots past the keep limit drop out, greatest first
            n_valid = n_valid && i_keep;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_link.valid = r_valid;
    assign o_link.stay  = w_stay;
    assign o_link.entry = r_entry;

endmodule

// ----- sv/k_nearest_to_origin_select_unit.sv -----
`timescale 1ns / 1ps

// Keeps the keep_count points nearest the origin out of a stream of signed points and,
// after the point flagged set_end, emits them farthest first on o_result_valid with
// o_final_result on the last one. Points are taken one per clock while busy is low.
// Each point passes through the squared-distance pipeline (one multiply stage, one add
// stage) and then lands in a sorted row of MAX_KEEP cells. A point with set_end raises
// busy while it is in that pipeline and through the emission state, in which the row
// shifts one cell per clock toward its output end until no cell but the output cell
// holds a point. Results come out for one cycle each and cannot be held off. keep_count is
// written through the cfg channel, which is ready only while busy is low; values above
// MAX_KEEP act as MAX_KEEP and zero keeps nothing.
module k_nearest_to_origin_select_unit (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic signed [knos_pkg::COORD_BITS-1:0] i_point_x,
    input  logic signed [knos_pkg::COORD_BITS-1:0] i_point_y,
    input  logic                                   i_set_end,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [knos_pkg::KEEP_BITS-1:0]         i_cfg_keep_count,
    output logic                                   o_result_valid,
    output logic signed [knos_pkg::COORD_BITS-1:0] o_out_x,
    output logic signed [knos_pkg::COORD_BITS-1:0] o_out_y,
    output logic [knos_pkg::DIST_BITS-1:0]         o_out_distance,
    output logic                                   o_final_result
);
    import knos_pkg::*;

    t_state                r_state;
    t_state                n_state;
    logic [KEEP_BITS-1:0]  r_keep;
    logic [LIMIT_BITS-1:0] w_limit;
    logic [MAX_KEEP-1:0]   w_keep;
    logic                  w_d_valid;
    logic                  w_d_end;
    logic                  w_end_pending;
    t_entry                w_d_entry;
    t_link                 w_link [MAX_KEEP+1];
    logic                  w_insert;
    logic                  w_shift;
    logic                  w_rest_valid;
    logic                  r_result_valid;
    logic                  r_final;
    t_entry                r_out_entry;

    knos_dist u_dist (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (start && !busy),
        .i_x           (i_point_x),
        .i_y           (i_point_y),
        .i_end         (i_set_end),
        .o_valid       (w_d_valid),
        .o_end         (w_d_end),
        .o_end_pending (w_end_pending),
        .o_entry       (w_d_entry)
    );

    always_comb begin
        if (int'(r_keep) > MAX_KEEP) begin
            w_limit = LIMIT_BITS'(MAX_KEEP);
        end else begin
            w_limit = LIMIT_BITS'(r_keep);
        end
    end

    // past the far end: empty, and everything stays ahead of it
    assign w_link[MAX_KEEP] = '{valid: 1'b0, stay: 1'b1, entry: '0};

    // row is right aligned: the highest cell holds the nearest point
    for (genvar g = 0; g < MAX_KEEP; g++) begin : g_cell
        assign w_keep[g] = (int'(w_limit) + g) >= MAX_KEEP;

        knos_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_insert (w_insert),
            .i_shift  (w_shift),
            .i_keep   (w_keep[g]),
            .i_new    (w_d_entry),
            .i_up     (w_link[g+1]),
            .o_link   (w_link[g])
        );
    end

    always_comb begin
        w_rest_valid = 1'b0;
        for (int i = 1; i <= MAX_KEEP; i++) begin
            w_rest_valid = w_rest_valid || w_link[i].valid;
        end
    end

    always_comb begin
        n_state  = r_state;
        w_insert = 1'b0;
        w_shift  = 1'b0;
        case (r_state)
            ST_RUN: begin
                w_insert = w_d_valid;
                if (w_d_valid && w_d_end) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                w_shift = 1'b1;
                if (!w_rest_valid) begin
                    n_state = ST_RUN;
                end
            end
            default: begin
                n_state = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_RUN;
            r_keep         <= KEEP_BITS'(1);
            r_result_valid <= 1'b0;
            r_final        <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_result_valid <= w_shift && w_link[0].valid;
            r_final        <= w_shift && w_link[0].valid && !w_link[1].valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_keep <= i_cfg_keep_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_entry <= w_link[0].entry;
    end

    assign busy           = (r_state == ST_EMIT) || w_end_pending;
    assign o_cfg_ready    = !busy;
    assign o_result_valid = r_result_valid;
    assign o_final_result = r_final;
    assign o_out_x        = r_out_entry.x;
    assign o_out_y        = r_out_entry.y;
    assign o_out_distance = r_out_entry.sq_dist;

endmodule

// ----- sv/knos_chk.sv -----
`timescale 1ns / 1ps

`include "assert_macros.svh"

module knos_chk (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic i_set_end,
    input logic o_result_valid,
    input logic o_final_result
);

    `KNOS_ASSERT_IMP(a_final_strobed, o_final_result, o_result_valid, "final flag without result")
    `KNOS_ASSERT_NXT(a_final_gap, o_final_result, !o_result_valid, "result after final")
    `KNOS_ASSERT_IMP(a_result_busy, o_result_valid, $past(busy), "result without busy before")
    `KNOS_ASSERT_NXT(a_end_busy, start && !busy && i_set_end, busy, "set end did not raise busy")

endmodule

bind k_nearest_to_origin_select_unit knos_chk u_knos_chk (.*);

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
    import knos_pkg::*;

    localparam int SETTLE    = 24;     // idle cycles before a keep_count write or a pause ends
    localparam int END_WAIT  = 40;
    localparam int MAX_CYCLE = 200000;
    localparam int RAND_PTS  = 200;

    typedef enum logic [1:0] {
        JOB_POINT,
        JOB_KEEP,
        JOB_DRAIN
    } t_job;

    typedef struct {
        t_job                   job;
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic                   last;
        logic [KEEP_BITS-1:0]   keep;
    } t_stim;

    typedef struct {
        logic [DIST_BITS-1:0]         sq_dist;
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
    } t_point;

    typedef struct {
        t_point pt;
        logic   last;
    } t_pick;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         start = 1'b0;
    logic                         busy;
    logic signed [COORD_BITS-1:0] i_point_x = '0;
    logic signed [COORD_BITS-1:0] i_point_y = '0;
    logic                         i_set_end = 1'b0;
    logic                         i_cfg_valid = 1'b0;
    logic                         o_cfg_ready;
    logic [KEEP_BITS-1:0]         i_cfg_keep_count = '0;
    logic                         o_result_valid;
    logic signed [COORD_BITS-1:0] o_out_x;
    logic signed [COORD_BITS-1:0] o_out_y;
    logic [DIST_BITS-1:0]         o_out_distance;
    logic                         o_final_result;

    t_stim  stim_q[$];
    t_point held_pts[$];       // kept points, farthest first
    t_pick  due_picks[$];
    logic [KEEP_BITS-1:0] keep_reg = KEEP_BITS'(1);
    int     quiet_cycles = 0;
    int     mismatches = 0;
    int     points_sent = 0;
    int     cycle_count = 0;

    k_nearest_to_origin_select_unit dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_point_x        (i_point_x),
        .i_point_y        (i_point_y),
        .i_set_end        (i_set_end),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_keep_count (i_cfg_keep_count),
        .o_result_valid   (o_result_valid),
        .o_out_x          (o_out_x),
        .o_out_y          (o_out_y),
        .o_out_distance   (o_out_distance),
        .o_final_result   (o_final_result)
    );

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > MAX_CYCLE) begin
            $display("k_nearest_to_origin_select_unit: mismatch");
            $finish;
        end
    end

    // eviction order: distance, then signed x, then signed y
    function automatic logic farther(t_point a, t_point b);
        if (a.sq_dist != b.sq_dist) return a.sq_dist > b.sq_dist;
        if (a.x != b.x) return $signed(a.x) > $signed(b.x);
        return $signed(a.y) > $signed(b.y);
    endfunction

    task automatic take_point(logic signed [COORD_BITS-1:0] x,
                              logic signed [COORD_BITS-1:0] y, logic last);
        t_point p;
        longint sx;
        longint sy;
        int     pos;
        int     limit;
        sx = x;
        sy = y;
        p.sq_dist = DIST_BITS'(sx * sx + sy * sy);
        p.x = x;
        p.y = y;
        pos = 0;
        while (pos < held_pts.size() && !farther(p, held_pts[pos])) pos++;
        held_pts.insert(pos, p);
        limit = (keep_reg > MAX_KEEP) ? MAX_KEEP : int'(keep_reg);
        while (held_pts.size() > limit) void'(held_pts.pop_front());
        if (last) begin
            foreach (held_pts[i]) begin
                due_picks.push_back('{pt: held_pts[i], last: (i == held_pts.size() - 1)});
            end
            held_pts.delete();
        end
    endtask

    // driver
    always @(posedge i_clk) begin
        t_stim nxt;
        logic  gap;
        gap = !(points_sent >= 90 && points_sent < 150) && ($urandom_range(0, 99) < 27);
        if (!i_rst_n) begin
            start <= 1'b0;
            i_cfg_valid <= 1'b0;
        end else if (i_cfg_valid) begin
            if (o_cfg_ready) i_cfg_valid <= 1'b0;
        end else if (start && busy) begin
            // hold the pending transaction
        end else if (stim_q.size() != 0 && stim_q[0].job == JOB_POINT && !gap) begin
            nxt = stim_q.pop_front();
            start <= 1'b1;
            i_point_x <= nxt.x;
            i_point_y <= nxt.y;
            i_set_end <= nxt.last;
            points_sent <= points_sent + 1;
        end else begin
            start <= 1'b0;
            if (stim_q.size() != 0 && stim_q[0].job != JOB_POINT && !start &&
                quiet_cycles >= SETTLE) begin
                nxt = stim_q.pop_front();
                if (nxt.job == JOB_KEEP) begin
                    i_cfg_valid <= 1'b1;
                    i_cfg_keep_count <= nxt.keep;
                end
            end
        end
    end

    // monitor and predictor
    always @(posedge i_clk) begin
        t_pick want;
        logic  took;
        took = start && !busy;
        if (i_rst_n) begin
            if (o_result_valid) begin
                if (due_picks.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: x=%0d y=%0d dist=%0d final=%0b",
                                 o_out_x, o_out_y, o_out_distance, o_final_result);
                end else begin
                    want = due_picks.pop_front();
                    if (o_out_x !== want.pt.x || o_out_y !== want.pt.y ||
                        o_out_distance !== want.pt.sq_dist ||
                        o_final_result !== want.last) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"wrong result: expected x=%0d y=%0d dist=%0d final=%0b,",
                                      " got x=%0d y=%0d dist=%0d final=%0b"},
                                     want.pt.x, want.pt.y, want.pt.sq_dist, want.last,
                                     o_out_x, o_out_y, o_out_distance, o_final_result);
                    end
                end
            end
            if (i_cfg_valid && o_cfg_ready) keep_reg = i_cfg_keep_count;
            if (took) take_point(i_point_x, i_point_y, i_set_end);
            if (due_picks.size() == 0 && !o_result_valid && !took && !i_cfg_valid)
                quiet_cycles <= quiet_cycles + 1;
            else
                quiet_cycles <= 0;
        end
    end

    function automatic logic signed [COORD_BITS-1:0] pick_coord();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return COORD_BITS'($urandom);
            5, 6, 7:       return COORD_BITS'(int'($urandom_range(0, 16)) - 8);
            8: begin
                case ($urandom_range(0, 3))
                    0:       return COORD_BITS'(-32768);
                    1:       return COORD_BITS'(32767);
                    2:       return COORD_BITS'(-1);
                    default: return COORD_BITS'(0);
                endcase
            end
            default:       return COORD_BITS'(int'($urandom_range(0, 600)) - 300);
        endcase
    endfunction

    task automatic add_point(int x, int y, logic last);
        stim_q.push_back('{job: JOB_POINT, x: COORD_BITS'(x), y: COORD_BITS'(y),
                           last: last, keep: '0});
    endtask

    task automatic add_keep(int v);
        stim_q.push_back('{job: JOB_KEEP, x: '0, y: '0, last: 1'b0, keep: KEEP_BITS'(v)});
    endtask

    task automatic add_drain();
        stim_q.push_back('{job: JOB_DRAIN, x: '0, y: '0, last: 1'b0, keep: '0});
    endtask

    initial begin
        int queued;
        int len;
        int keep_opts[7];

        keep_opts = '{0, 1, 2, 15, 16, 17, 31};

        // keep one point at reset value; corner coordinates
        add_point(32767, 32767, 1'b0);
        add_point(-32768, -32768, 1'b0);
        add_point(0, 0, 1'b1);
        // ties on distance, duplicates
        add_keep(16);
        add_point(3, 4, 1'b0);
        add_point(4, 3, 1'b0);
        add_point(-3, 4, 1'b0);
        add_point(3, -4, 1'b0);
        add_point(5, 0, 1'b0);
        add_point(0, -5, 1'b0);
        add_point(-5, 0, 1'b0);
        add_point(3, 4, 1'b0);
        add_point(-32768, 0, 1'b1);
        // keep count lowered in the middle of a set
        add_keep(3);
        add_point(1, 1, 1'b0);
        add_point(2, 2, 1'b0);
        add_point(-1, -1, 1'b0);
        add_keep(1);
        add_point(10, 10, 1'b1);
        // zero keeps nothing
        add_keep(0);
        add_point(7, 7, 1'b0);
        add_point(-32768, 32767, 1'b1);
        // above the maximum saturates
        add_keep(31);
        add_point(1, 0, 1'b1);
        add_drain();
        add_keep(17);
        add_point(32767, -32768, 1'b1);

        queued = 0;
        while (queued < RAND_PTS) begin
            if ($urandom_range(0, 2) == 0) begin
                if ($urandom_range(0, 3) == 0)
                    add_keep($urandom_range(0, 31));
                else
                    add_keep(keep_opts[$urandom_range(0, 6)]);
            end
            if ($urandom_range(0, 5) == 0) add_drain();
            len = ($urandom_range(0, 4) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 16);
            for (int i = 0; i < len; i++) begin
                if (i > 0 && i < len - 1 && $urandom_range(0, 40) == 0)
                    add_keep($urandom_range(0, 31));
                add_point(pick_coord(), pick_coord(), i == len - 1);
            end
            queued += len;
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // sample away from the active edge so the driver's pops have settled
        @(negedge i_clk);
        while (stim_q.size() != 0 || start || i_cfg_valid) @(negedge i_clk);
        while (quiet_cycles < END_WAIT) @(negedge i_clk);
        if (mismatches == 0)
            $display("k_nearest_to_origin_select_unit: match");
        else
            $display("k_nearest_to_origin_select_unit: mismatch");
        $finish;
    end

endmodule
